// ----- sv/psg_fx_pkg.sv -----
// shared types and constants for the psg effect sequencer
// no dependencies; imported by psg_fx_oreg, psg_fx_seq and the top level
package psg_fx_pkg;

  localparam int STORE_BYTES_DEF = 4096;
  localparam int SPC_DEF         = 4;
  localparam int CHANNELS        = 4;

  localparam logic [2:0] K_LOAD  = 3'd0;
  localparam logic [2:0] K_START = 3'd1;
  localparam logic [2:0] K_STOP  = 3'd2;
  localparam logic [2:0] K_PLAY  = 3'd3;
  localparam logic [2:0] K_TICK  = 3'd4;

  localparam logic [7:0] CHIP_MUTE0   = 8'h9f;
  localparam logic [7:0] CHIP_VOL     = 8'h90;
  localparam logic [7:0] CHIP_DIV     = 8'h80;
  localparam logic [4:0] WAIT_MAX     = 5'd31;
  localparam logic [15:0] AGE_MAX     = 16'hffff;

  typedef struct packed {
    logic        valid;
    logic [7:0]  chip_byte;
    logic [15:0] effect_count;
    logic        last;
  } out_req_t;

endpackage

// ----- sv/psg_fx_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module psg_fx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/psg_fx_oreg.sv -----
// result register between the sequencer and the output channel
// depends on psg_fx_pkg
module psg_fx_oreg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psg_fx_pkg::out_req_t req,
  output logic                 req_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_chip_byte,
  output logic [15:0]          out_effect_count,
  output logic                 out_last
);
  import psg_fx_pkg::*;

  logic        valid_r;
  logic [7:0]  byte_r;
  logic [15:0] count_r;
  logic        last_r;

  assign req_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req_ready) begin
      valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req_ready) begin
      byte_r  <= req.chip_byte;
      count_r <= req.effect_count;
      last_r  <= req.last;
    end
  end

  assign out_valid        = valid_r;
  assign out_chip_byte    = byte_r;
  assign out_effect_count = count_r;
  assign out_last         = last_r;

endmodule

// ----- sv/psg_fx_seq.sv -----
// sequencer: byte store, slot record memory and the control that walks them
// depends on psg_fx_pkg and psg_fx_ram
module psg_fx_seq #(
  parameter int STORE_BYTES       = psg_fx_pkg::STORE_BYTES_DEF,
  parameter int SLOTS_PER_CHANNEL = psg_fx_pkg::SPC_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_kind,
  input  logic [11:0]          in_address,
  input  logic [7:0]           in_value,
  input  logic [15:0]          in_effect_number,
  output psg_fx_pkg::out_req_t req,
  input  logic                 req_ready
);
  import psg_fx_pkg::*;

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int SPC = SLOTS_PER_CHANNEL;
  localparam int SC  = CHANNELS * SPC;
  localparam int SW  = $clog2(SC);
  localparam int KW  = (SPC > 1) ? $clog2(SPC) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(SPC - 1);
  localparam logic [3:0]    SPC_N  = 4'(SPC);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ST1   = 5'd1;
  localparam logic [4:0] S_ST2   = 5'd2;
  localparam logic [4:0] S_SEMIT = 5'd3;
  localparam logic [4:0] S_PL1   = 5'd4;
  localparam logic [4:0] S_PL2   = 5'd5;
  localparam logic [4:0] S_PL3   = 5'd6;
  localparam logic [4:0] S_PT0   = 5'd7;
  localparam logic [4:0] S_PT1   = 5'd8;
  localparam logic [4:0] S_PT2   = 5'd9;
  localparam logic [4:0] S_PT3   = 5'd10;
  localparam logic [4:0] S_OLDA  = 5'd11;
  localparam logic [4:0] S_OLDD  = 5'd12;
  localparam logic [4:0] S_PLRD  = 5'd13;
  localparam logic [4:0] S_PLWR  = 5'd14;
  localparam logic [4:0] S_TSLOT = 5'd15;
  localparam logic [4:0] S_TREC  = 5'd16;
  localparam logic [4:0] S_TOP   = 5'd17;
  localparam logic [4:0] S_TOP2  = 5'd18;
  localparam logic [4:0] S_TEMIT = 5'd19;

  typedef struct packed {
    logic [AW-1:0] pos;
    logic [4:0]    wt;
    logic [15:0]   age;
    logic [15:0]   dv;
    logic [3:0]    vol;
  } rec_t;

  // storage
  logic          st_we;
  logic [AW-1:0] st_addr;
  logic [7:0]    st_wdata, st_rdata;
  logic          rc_we;
  logic [SW-1:0] rc_addr;
  rec_t          rc_wdata, rc_rdata, rec_rd;

  psg_fx_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk(clk), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata)
  );

  psg_fx_ram #(.WIDTH($bits(rec_t)), .DEPTH(SC)) u_slots (
    .clk(clk), .we(rc_we), .addr(rc_addr), .wdata(rc_wdata), .rdata(rc_rdata)
  );

  // control state
  logic [4:0]    state_r, state_nxt;
  logic          enabled_r, enabled_nxt;
  logic [15:0]   total_r, total_nxt;
  logic [SC-1:0] active_r, active_nxt;
  logic [SC-1:0] recv_r, recv_nxt;
  logic [1:0]    ch_r, ch_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] pick_r, pick_nxt;
  logic [7:0]    parts_r, parts_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          have_old_r, have_old_nxt;
  logic [3:0]    bhave_r, bhave_nxt;

  // payload
  logic [7:0]    hi_r, hi_nxt;
  logic [7:0]    b_r, b_nxt;
  logic [AW-1:0] d_r, d_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [15:0]   old_age_r, old_age_nxt;
  rec_t          cur_r, cur_nxt;
  logic [3:0]    bvol_r [CHANNELS];
  logic [3:0]    bvol_nxt [CHANNELS];
  logic [15:0]   bdiv_r [CHANNELS];
  logic [15:0]   bdiv_nxt [CHANNELS];

  logic [KW-1:0] sel_k;
  logic [SW-1:0] rec_slot;
  logic [17:0]   e_full;
  logic [15:0]   ptr16;

  assign sel_k    = (state_r == S_PLRD || state_r == S_PLWR) ? pick_r : k_r;
  assign rec_slot = SW'(32'(ch_r) * SPC + 32'(sel_k));
  // an entry never written reads as the reset record
  assign rec_rd   = recv_r[rec_slot] ? rc_rdata : '0;
  assign e_full   = {1'b0, in_effect_number, 1'b0} + 18'd2;
  assign ptr16    = {hi_r, st_rdata};
  assign in_ready = (state_r == S_IDLE);

  function automatic logic [3:0] busy_cnt(input logic [SC-1:0] act, input int ch);
    logic [3:0] c;
    c = 4'd0;
    for (int k = 0; k < SPC; k++) begin
      c = c + 4'(act[SW'(ch * SPC + k)]);
    end
    return c;
  endfunction

  always_comb begin
    logic [1:0]    tgt;
    logic          skip, done, free_found, wr_now, adv_now, keep_act, higher;
    logic [3:0]    best, cnt;
    logic [KW-1:0] free_k;
    rec_t          upd;

    state_nxt    = state_r;
    enabled_nxt  = enabled_r;
    total_nxt    = total_r;
    active_nxt   = active_r;
    recv_nxt     = recv_r;
    ch_nxt       = ch_r;
    k_nxt        = k_r;
    pick_nxt     = pick_r;
    parts_nxt    = parts_r;
    idx_nxt      = idx_r;
    have_old_nxt = have_old_r;
    bhave_nxt    = bhave_r;
    hi_nxt       = hi_r;
    b_nxt        = b_r;
    d_nxt        = d_r;
    pos_nxt      = pos_r;
    old_age_nxt  = old_age_r;
    cur_nxt      = cur_r;
    bvol_nxt     = bvol_r;
    bdiv_nxt     = bdiv_r;

    st_we    = 1'b0;
    st_addr  = d_r;
    st_wdata = in_value;
    rc_we    = 1'b0;
    rc_addr  = rec_slot;
    rc_wdata = cur_r;
    req      = '0;

    tgt        = 2'd0;
    skip       = 1'b0;
    done       = 1'b0;
    free_found = 1'b0;
    free_k     = '0;
    best       = SPC_N;
    cnt        = 4'd0;
    wr_now     = 1'b0;
    adv_now    = 1'b0;
    keep_act   = 1'b1;
    higher     = 1'b0;
    upd        = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            K_LOAD: begin
              st_we   = 1'b1;
              st_addr = AW'(in_address);
            end
            K_START: begin
              st_addr   = '0;
              state_nxt = S_ST1;
            end
            K_STOP: enabled_nxt = 1'b0;
            K_PLAY: begin
              if (enabled_r && in_effect_number < total_r) begin
                st_addr   = e_full[AW-1:0];
                d_nxt     = e_full[AW-1:0];
                state_nxt = S_PL1;
              end
            end
            K_TICK: begin
              if (enabled_r) begin
                ch_nxt    = 2'd0;
                k_nxt     = '0;
                bhave_nxt = 4'd0;
                state_nxt = S_TSLOT;
              end
            end
            default: ;
          endcase
        end
      end
      S_ST1: begin
        st_addr   = AW'(1);
        hi_nxt    = st_rdata;
        state_nxt = S_ST2;
      end
      S_ST2: begin
        total_nxt   = {hi_r, st_rdata};
        active_nxt  = '0;
        enabled_nxt = 1'b1;
        idx_nxt     = 2'd0;
        state_nxt   = S_SEMIT;
      end
      S_SEMIT: begin
        req.valid        = 1'b1;
        req.chip_byte    = CHIP_MUTE0 | {1'b0, idx_r, 5'd0};
        req.effect_count = total_r;
        req.last         = (idx_r == 2'd3);
        if (req_ready) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) state_nxt = S_IDLE;
        end
      end
      S_PL1: begin
        st_addr   = d_r + AW'(1);
        hi_nxt    = st_rdata;
        state_nxt = S_PL2;
      end
      S_PL2: begin
        st_addr   = ptr16[AW-1:0];
        d_nxt     = ptr16[AW-1:0] + AW'(1);
        state_nxt = S_PL3;
      end
      S_PL3: begin
        parts_nxt = st_rdata;
        st_addr   = d_r;
        state_nxt = (st_rdata == 8'd0) ? S_IDLE : S_PT1;
      end
      S_PT0: begin
        st_addr   = d_r;
        state_nxt = S_PT1;
      end
      S_PT1: begin
        st_addr   = d_r + AW'(1);
        hi_nxt    = st_rdata;
        state_nxt = S_PT2;
      end
      S_PT2: begin
        st_addr   = ptr16[AW-1:0];
        pos_nxt   = ptr16[AW-1:0] + AW'(1);
        d_nxt     = d_r + AW'(2);
        state_nxt = S_PT3;
      end
      S_PT3: begin
        tgt  = st_rdata[1:0];
        skip = |st_rdata[7:2];
        // tone parts go to the least busy tone channel, highest first (named channel if all full)
        if (st_rdata[7:1] == 7'd0) begin
          for (int i = 2; i >= 0; i--) begin
            cnt = busy_cnt(active_r, i);
            if (!done) begin
              if (cnt == 4'd0) begin
                tgt  = 2'(i);
                done = 1'b1;
              end else if (cnt < best) begin
                best = cnt;
                tgt  = 2'(i);
              end
            end
          end
        end
        for (int k = SPC - 1; k >= 0; k--) begin
          if (!active_r[SW'(32'(tgt) * SPC + k)]) begin
            free_found = 1'b1;
            free_k     = KW'(k);
          end
        end
        if (skip) begin
          if (parts_r == 8'd1) begin
            state_nxt = S_IDLE;
          end else begin
            parts_nxt = parts_r - 8'd1;
            state_nxt = S_PT0;
          end
        end else begin
          ch_nxt = tgt;
          if (free_found) begin
            pick_nxt  = free_k;
            state_nxt = S_PLRD;
          end else begin
            k_nxt        = '0;
            have_old_nxt = 1'b0;
            state_nxt    = S_OLDA;
          end
        end
      end
      S_OLDA: state_nxt = S_OLDD;
      S_OLDD: begin
        if (!have_old_r || rec_rd.age > old_age_r) begin
          old_age_nxt  = rec_rd.age;
          pick_nxt     = k_r;
          have_old_nxt = 1'b1;
        end
        if (k_r == K_LAST) begin
          state_nxt = S_PLRD;
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = S_OLDA;
        end
      end
      S_PLRD: state_nxt = S_PLWR;
      S_PLWR: begin
        upd      = rec_rd;
        upd.pos  = pos_r;
        upd.wt   = 5'd0;
        upd.age  = 16'd0;
        rc_we    = 1'b1;
        rc_wdata = upd;
        recv_nxt[rec_slot]   = 1'b1;
        active_nxt[rec_slot] = 1'b1;
        if (parts_r == 8'd1) begin
          state_nxt = S_IDLE;
        end else begin
          parts_nxt = parts_r - 8'd1;
          state_nxt = S_PT0;
        end
      end
      S_TSLOT: begin
        if (active_r[rec_slot]) state_nxt = S_TREC;
        else adv_now = 1'b1;
      end
      S_TREC: begin
        upd     = rec_rd;
        upd.age = (rec_rd.age == AGE_MAX) ? rec_rd.age : rec_rd.age + 16'd1;
        if (rec_rd.wt != 5'd0) begin
          upd.wt = rec_rd.wt - 5'd1;
          wr_now = 1'b1;
        end else begin
          cur_nxt   = upd;
          st_addr   = rec_rd.pos;
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        upd     = cur_r;
        upd.pos = cur_r.pos + AW'(1);
        unique case (st_rdata[7:6])
          2'b00: begin
            wr_now = 1'b1;
            if (st_rdata == 8'd0) begin
              keep_act = 1'b0;
            end else begin
              upd.wt = (st_rdata > 8'd32) ? WAIT_MAX : 5'(st_rdata - 8'd1);
            end
          end
          2'b01: begin
            wr_now  = 1'b1;
            upd.vol = st_rdata[3:0];
          end
          2'b10, 2'b11: begin
            b_nxt       = st_rdata;
            st_addr     = cur_r.pos + AW'(1);
            cur_nxt.pos = cur_r.pos + AW'(2);
            state_nxt   = S_TOP2;
          end
        endcase
      end
      S_TOP2: begin
        upd    = cur_r;
        wr_now = 1'b1;
        if (!b_r[6]) begin
          upd.dv = {b_r, st_rdata};
        end else begin
          upd.vol = b_r[5:2];
          upd.dv  = {6'd0, b_r[1:0], st_rdata};
        end
      end
      S_TEMIT: begin
        for (int j = 0; j < CHANNELS; j++) begin
          if (j > 32'(ch_r) && bhave_r[j]) higher = 1'b1;
        end
        if (!bhave_r[ch_r]) begin
          if (ch_r == 2'd3) state_nxt = S_IDLE;
          else ch_nxt = ch_r + 2'd1;
        end else begin
          req.valid = 1'b1;
          req.last  = (idx_r == 2'd2) && !higher;
          case (idx_r)
            2'd0: req.chip_byte = CHIP_VOL | {1'b0, ch_r, 5'd0} | {4'd0, bvol_r[ch_r]};
            2'd1: req.chip_byte = CHIP_DIV | {1'b0, ch_r, 5'd0} | {4'd0, bdiv_r[ch_r][3:0]};
            default: req.chip_byte = bdiv_r[ch_r][11:4];
          endcase
          if (req_ready) begin
            if (idx_r == 2'd2) begin
              idx_nxt = 2'd0;
              if (ch_r == 2'd3) state_nxt = S_IDLE;
              else ch_nxt = ch_r + 2'd1;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // write back a stepped slot and track the loudest one per channel
    if (wr_now) begin
      rc_we              = 1'b1;
      rc_wdata           = upd;
      recv_nxt[rec_slot] = 1'b1;
      if (!keep_act) begin
        active_nxt[rec_slot] = 1'b0;
      end else if (!bhave_r[ch_r] || upd.vol < bvol_r[ch_r]) begin
        bhave_nxt[ch_r] = 1'b1;
        bvol_nxt[ch_r]  = upd.vol;
        bdiv_nxt[ch_r]  = upd.dv;
      end
      adv_now = 1'b1;
    end
    if (adv_now) begin
      if (k_r == K_LAST) begin
        k_nxt = '0;
        if (ch_r == 2'd3) begin
          ch_nxt    = 2'd0;
          idx_nxt   = 2'd0;
          state_nxt = S_TEMIT;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_TSLOT;
        end
      end else begin
        k_nxt     = k_r + KW'(1);
        state_nxt = S_TSLOT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      enabled_r  <= 1'b0;
      total_r    <= 16'd0;
      active_r   <= '0;
      recv_r     <= '0;
      ch_r       <= 2'd0;
      k_r        <= '0;
      pick_r     <= '0;
      parts_r    <= 8'd0;
      idx_r      <= 2'd0;
      have_old_r <= 1'b0;
      bhave_r    <= 4'd0;
    end else begin
      state_r    <= state_nxt;
      enabled_r  <= enabled_nxt;
      total_r    <= total_nxt;
      active_r   <= active_nxt;
      recv_r     <= recv_nxt;
      ch_r       <= ch_nxt;
      k_r        <= k_nxt;
      pick_r     <= pick_nxt;
      parts_r    <= parts_nxt;
      idx_r      <= idx_nxt;
      have_old_r <= have_old_nxt;
      bhave_r    <= bhave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r      <= hi_nxt;
    b_r       <= b_nxt;
    d_r       <= d_nxt;
    pos_r     <= pos_nxt;
    old_age_r <= old_age_nxt;
    cur_r     <= cur_nxt;
    bvol_r    <= bvol_nxt;
    bdiv_r    <= bdiv_nxt;
  end

  a_req_states: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> (state_r == S_SEMIT || state_r == S_TEMIT))
    else $error("result requested outside an emission state");

  a_stop_disables: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == K_STOP) |=> !enabled_r)
    else $error("stop transaction left the block enabled");

  a_place_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLWR) |=> active_r[$past(rec_slot)])
    else $error("placed slot not marked active");

  a_active_written: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TREC) |-> recv_r[rec_slot])
    else $error("stepping a slot whose record was never written");

endmodule

// ----- sv/psg_effect_sequencer.sv -----
// top level of the psg effect sequencer
// depends on psg_fx_pkg, psg_fx_seq and psg_fx_oreg
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid in_ready in_kind in_address in_value   | input
//          | in_effect_number                               |
//  out     | out_valid out_ready out_chip_byte              | output
//          | out_effect_count out_last                      |
//
// load writes a byte and stop clears the enable; start reads the effect count
// and emits four results; play reads the effect's part list and places each
// part in a free slot, in the oldest slot when the channel is full, or skips
// it; a tick steps every active slot, then emits three results per channel that
// still has an active slot; the byte store has a single port, read one byte per
// cycle with a registered read.
// reset clears control state only; the byte store holds garbage until loaded.
// a stalled result holds the sequencer, which still finishes into the output
// register and takes the next transaction while the last result waits.
module psg_effect_sequencer #(
  parameter int STORE_BYTES       = psg_fx_pkg::STORE_BYTES_DEF,
  parameter int SLOTS_PER_CHANNEL = psg_fx_pkg::SPC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_value,
  input  logic [15:0] in_effect_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_chip_byte,
  output logic [15:0] out_effect_count,
  output logic        out_last
);
  import psg_fx_pkg::*;

  out_req_t req;
  logic     req_ready;

  psg_fx_seq #(
    .STORE_BYTES(STORE_BYTES),
    .SLOTS_PER_CHANNEL(SLOTS_PER_CHANNEL)
  ) u_seq (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_address(in_address), .in_value(in_value),
    .in_effect_number(in_effect_number),
    .req(req), .req_ready(req_ready)
  );

  psg_fx_oreg u_oreg (
    .clk(clk), .rst_n(rst_n),
    .req(req), .req_ready(req_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_chip_byte(out_chip_byte), .out_effect_count(out_effect_count),
    .out_last(out_last)
  );

endmodule
